### hw/rtl/tank_fill_controller_with_timeout_assert.svh
// Assertion macros for the tank fill controller checks
`ifndef TANK_FILL_CONTROLLER_WITH_TIMEOUT_ASSERT_SVH
`define TANK_FILL_CONTROLLER_WITH_TIMEOUT_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define TFC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define TFC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/tfc_pkg.sv
// Shared types and constants of the tank fill controller
`default_nettype none
package tfc_pkg;

	localparam int unsigned LEVEL_W = 8;
	localparam int unsigned TICKS_W = 16;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned QUEUE_DEPTH = 2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FULL_LEVEL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FILL_LEVEL = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_WARN_LEVEL = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EMPTY_ERROR_LEVEL = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FILL_TIMEOUT_TICKS = 3'd4;

	// register reset values
	localparam logic [LEVEL_W-1:0] FULL_LEVEL_RST = 8'd145;
	localparam logic [LEVEL_W-1:0] FILL_LEVEL_RST = 8'd155;
	localparam logic [LEVEL_W-1:0] LOW_WARN_LEVEL_RST = 8'd165;
	localparam logic [LEVEL_W-1:0] EMPTY_ERROR_LEVEL_RST = 8'd175;
	localparam logic [TICKS_W-1:0] FILL_TIMEOUT_RST = TICKS_W'(2 * 60 * 30);

	// tank modes
	localparam logic [1:0] MODE_INITIAL = 2'd0;
	localparam logic [1:0] MODE_FULL = 2'd1;
	localparam logic [1:0] MODE_FILLING = 2'd2;
	localparam logic [1:0] MODE_ERROR = 2'd3;

	// lamp colours
	localparam logic [2:0] LAMP_BLUE = 3'd0;
	localparam logic [2:0] LAMP_GREEN = 3'd1;
	localparam logic [2:0] LAMP_YELLOW = 3'd2;
	localparam logic [2:0] LAMP_RED = 3'd3;
	localparam logic [2:0] LAMP_OFF = 3'd4;

	// classified item, front to back
	typedef struct packed {
		logic is_tick;
		logic below_full;
		logic above_fill;
		logic above_warn;
		logic above_empty;
	} cmd_t;

	// queue status seen by the front and back
	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage
`default_nettype wire

### hw/rtl/tfc_in_if.sv
// Input item channel: level samples and timer ticks
`default_nettype none
interface tfc_in_if;
	logic valid;
	logic ready;
	logic func;
	logic [tfc_pkg::LEVEL_W-1:0] level_sample;

	modport source (output valid, output func, output level_sample, input ready);
	modport sink (input valid, input func, input level_sample, output ready);
endinterface
`default_nettype wire

### hw/rtl/tfc_out_if.sv
// Result channel: valve, mode and lamp
`default_nettype none
interface tfc_out_if;
	logic valid;
	logic ready;
	logic valve_open;
	logic [1:0] tank_state;
	logic [2:0] lamp_colour;
	logic lamp_update;

	modport source (output valid, output valve_open, output tank_state,
		output lamp_colour, output lamp_update, input ready);
	modport sink (input valid, input valve_open, input tank_state,
		input lamp_colour, input lamp_update, output ready);
endinterface
`default_nettype wire

### hw/rtl/tfc_cfg_if.sv
// Configuration write channel
`default_nettype none
interface tfc_cfg_if;
	logic valid;
	logic ready;
	logic [tfc_pkg::CFG_IDX_W-1:0] index;
	logic [tfc_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### hw/rtl/tfc_front.sv
// Front end: threshold registers, item accept and classification
`default_nettype none
module tfc_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	tfc_in_if.sink                             items,
	tfc_cfg_if.sink                            cfg,
	input  wire tfc_pkg::queue_status_t        q_status,
	output logic                               push,
	output tfc_pkg::cmd_t                      push_cmd,
	output logic [tfc_pkg::TICKS_W-1:0]        fill_timeout
);

	logic [tfc_pkg::LEVEL_W-1:0] full_level_q;
	logic [tfc_pkg::LEVEL_W-1:0] fill_level_q;
	logic [tfc_pkg::LEVEL_W-1:0] low_warn_level_q;
	logic [tfc_pkg::LEVEL_W-1:0] empty_error_level_q;
	logic [tfc_pkg::TICKS_W-1:0] fill_timeout_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_level_q <= tfc_pkg::FULL_LEVEL_RST;
			fill_level_q <= tfc_pkg::FILL_LEVEL_RST;
			low_warn_level_q <= tfc_pkg::LOW_WARN_LEVEL_RST;
			empty_error_level_q <= tfc_pkg::EMPTY_ERROR_LEVEL_RST;
			fill_timeout_q <= tfc_pkg::FILL_TIMEOUT_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				tfc_pkg::REG_FULL_LEVEL: full_level_q <= cfg.data[tfc_pkg::LEVEL_W-1:0];
				tfc_pkg::REG_FILL_LEVEL: fill_level_q <= cfg.data[tfc_pkg::LEVEL_W-1:0];
				tfc_pkg::REG_LOW_WARN_LEVEL: begin
					low_warn_level_q <= cfg.data[tfc_pkg::LEVEL_W-1:0];
				end
				tfc_pkg::REG_EMPTY_ERROR_LEVEL: begin
					empty_error_level_q <= cfg.data[tfc_pkg::LEVEL_W-1:0];
				end
				tfc_pkg::REG_FILL_TIMEOUT_TICKS: fill_timeout_q <= cfg.data;
				default: ;
			endcase
		end
	end

	assign items.ready = !q_status.full;
	assign push = items.valid && !q_status.full;
	assign fill_timeout = fill_timeout_q;

	// the user must change thresholds only while idle; the block does not enforce this, and compares are taken at accept
	always_comb begin
		push_cmd.is_tick = items.func;
		push_cmd.below_full = items.level_sample < full_level_q;
		push_cmd.above_fill = items.level_sample > fill_level_q;
		push_cmd.above_warn = items.level_sample > low_warn_level_q;
		push_cmd.above_empty = items.level_sample > empty_error_level_q;
	end

endmodule
`default_nettype wire

### hw/rtl/tfc_queue.sv
// Short command queue between front and back
`default_nettype none
module tfc_queue (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   push,
	input  wire tfc_pkg::cmd_t          push_cmd,
	input  wire logic                   pop,
	output tfc_pkg::cmd_t               pop_cmd,
	output tfc_pkg::queue_status_t      status
);

	localparam int unsigned PTR_W = $clog2(tfc_pkg::QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(tfc_pkg::QUEUE_DEPTH + 1);

	tfc_pkg::cmd_t slot_q [tfc_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign status.full = count_q == CNT_W'(tfc_pkg::QUEUE_DEPTH);
	assign status.empty = count_q == '0;
	assign pop_cmd = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(tfc_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(tfc_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

### hw/rtl/tfc_back.sv
// Back end: tank mode machine, fill timer and result register
`default_nettype none
module tfc_back (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire tfc_pkg::queue_status_t    q_status,
	input  wire tfc_pkg::cmd_t             pop_cmd,
	input  wire logic [tfc_pkg::TICKS_W-1:0] fill_timeout,
	output logic                           pop,
	tfc_out_if.source                      results
);

	typedef enum logic [1:0] {
		ST_INITIAL = tfc_pkg::MODE_INITIAL,
		ST_FULL    = tfc_pkg::MODE_FULL,
		ST_FILLING = tfc_pkg::MODE_FILLING,
		ST_ERROR   = tfc_pkg::MODE_ERROR
	} mode_t;

	mode_t mode_q;
	mode_t mode_d;
	logic valve_q;
	logic valve_d;
	logic [2:0] colour_q;
	logic [2:0] colour_d;
	logic [tfc_pkg::TICKS_W-1:0] count_q;
	logic [tfc_pkg::TICKS_W-1:0] count_d;
	logic [tfc_pkg::TICKS_W-1:0] count_inc;

	logic out_valid_q;
	logic out_valve_q;
	logic [1:0] out_state_q;
	logic [2:0] out_colour_q;
	logic out_update_q;

	assign pop = !q_status.empty && (!out_valid_q || results.ready);

	assign count_inc = (count_q == '1) ? count_q : count_q + 1'b1;

	// checks apply in order; each sees the result of the one before
	always_comb begin
		mode_d = mode_q;
		valve_d = valve_q;
		colour_d = colour_q;
		count_d = count_q;
		if (pop_cmd.is_tick) begin
			if (mode_q == ST_FILLING) begin
				count_d = count_inc;
				if (count_inc > fill_timeout) begin
					mode_d = ST_ERROR;
					valve_d = 1'b0;
					colour_d = tfc_pkg::LAMP_RED;
				end
			end else begin
				count_d = '0;
			end
		end else if (mode_q != ST_ERROR) begin
			if (pop_cmd.below_full && mode_d != ST_FULL) begin
				mode_d = ST_FULL;
				valve_d = 1'b0;
				colour_d = tfc_pkg::LAMP_BLUE;
			end
			if (pop_cmd.above_fill && mode_d != ST_FILLING) begin
				mode_d = ST_FILLING;
				valve_d = 1'b1;
				colour_d = tfc_pkg::LAMP_GREEN;
			end
			if (pop_cmd.above_empty) begin
				mode_d = ST_ERROR;
				valve_d = 1'b0;
				colour_d = tfc_pkg::LAMP_RED;
			end
			if (pop_cmd.above_warn && mode_d == ST_FILLING) begin
				colour_d = tfc_pkg::LAMP_YELLOW;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ST_INITIAL;
			valve_q <= 1'b0;
			colour_q <= tfc_pkg::LAMP_OFF;
			count_q <= '0;
			out_valid_q <= 1'b0;
			out_valve_q <= 1'b0;
			out_state_q <= tfc_pkg::MODE_INITIAL;
			out_colour_q <= tfc_pkg::LAMP_OFF;
			out_update_q <= 1'b0;
		end else begin
			if (pop) begin
				mode_q <= mode_d;
				valve_q <= valve_d;
				colour_q <= colour_d;
				count_q <= count_d;
				out_valid_q <= 1'b1;
				out_valve_q <= valve_d;
				out_state_q <= mode_d;
				out_colour_q <= colour_d;
				out_update_q <= colour_d != colour_q;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign results.valid = out_valid_q;
	assign results.valve_open = out_valve_q;
	assign results.tank_state = out_state_q;
	assign results.lamp_colour = out_colour_q;
	assign results.lamp_update = out_update_q;

endmodule
`default_nettype wire

### hw/rtl/tank_fill_controller_with_timeout.sv
// Tank fill controller: top level
//
// items: one beat is a level sample (func 0) or a timer tick (func 1).
// results: one beat per item, in order: valve drive, tank mode, lamp colour
//   and a strobe set when the colour changed on that item.
// cfg: register writes (0 full, 1 fill, 2 low warn, 3 empty error levels,
//   4 fill timeout in ticks); always ready, unknown indexes are dropped.
//   Write only with no items in flight.
// Path: an accepted item is written to the queue; the back pops it into the
//   result register unless that register still holds a beat not yet taken.
// Throughput: one item per cycle; the front classifies against the
//   thresholds, a two-entry queue decouples it from the mode machine in the
//   back, which retires one item per cycle into the result register.
// Stall: with results.ready low the result register holds, the queue fills
//   and items.ready drops once both entries are taken.
// Reset: thresholds return to defaults, mode initial, valve closed, lamp
//   off, timer cleared, queue and result register empty. Error mode is
//   held until the next reset.
`default_nettype none
`include "tank_fill_controller_with_timeout_assert.svh"
module tank_fill_controller_with_timeout (
	input  wire logic clk,
	input  wire logic arst_n,
	tfc_in_if.sink    items,
	tfc_out_if.source results,
	tfc_cfg_if.sink   cfg
);

	tfc_pkg::queue_status_t q_status;
	tfc_pkg::cmd_t push_cmd;
	tfc_pkg::cmd_t pop_cmd;
	logic push;
	logic pop;
	logic [tfc_pkg::TICKS_W-1:0] fill_timeout;

	// result-side decodes for the checks below
	logic res_error;
	logic valve_ok;
	logic red_closed;
	logic off_ok;
	logic valid_error;
	logic taken_error;

	tfc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.items        (items),
		.cfg          (cfg),
		.q_status     (q_status),
		.push         (push),
		.push_cmd     (push_cmd),
		.fill_timeout (fill_timeout)
	);

	tfc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.status   (q_status)
	);

	tfc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_status     (q_status),
		.pop_cmd      (pop_cmd),
		.fill_timeout (fill_timeout),
		.pop          (pop),
		.results      (results)
	);

	assign res_error = results.tank_state == tfc_pkg::MODE_ERROR;
	assign valve_ok = results.valve_open == (results.tank_state == tfc_pkg::MODE_FILLING);
	assign red_closed = results.lamp_colour == tfc_pkg::LAMP_RED && !results.valve_open;
	assign off_ok = (results.lamp_colour == tfc_pkg::LAMP_OFF) ==
		(results.tank_state == tfc_pkg::MODE_INITIAL);
	assign valid_error = results.valid && res_error;
	assign taken_error = results.valid && results.ready && res_error;

	`TFC_ASSERT_IMP(a_valve_tracks_filling, results.valid, valve_ok, "valve drive vs mode")
	`TFC_ASSERT_IMP(a_error_shows_red, valid_error, red_closed, "error without red and closed")
	`TFC_ASSERT_IMP(a_off_only_initial, results.valid, off_ok, "lamp off outside initial")
	`TFC_ASSERT_NXT(a_error_latched, taken_error, !results.valid || res_error, "error mode left")

endmodule
`default_nettype wire

### tb/tb.sv
// Self-checking testbench for the tank fill controller: directed plan, then random phases
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic FUNC_SAMPLE = 1'b0;
	localparam logic FUNC_TICK = 1'b1;
	localparam logic [tfc_pkg::CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd5;
	localparam logic [tfc_pkg::CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;
	localparam int unsigned IDLE_LIMIT = 4000;
	localparam int unsigned NUM_PHASES = 7;

	typedef struct packed {
		logic valve_open;
		logic [1:0] tank_state;
		logic [2:0] lamp_colour;
		logic lamp_update;
	} tank_status_t;

	typedef struct packed {
		logic is_reg;
		logic func;
		logic [tfc_pkg::LEVEL_W-1:0] level;
		logic [tfc_pkg::CFG_IDX_W-1:0] idx;
		logic [tfc_pkg::CFG_DATA_W-1:0] data;
		logic typed;
		tank_status_t want;
	} plan_row_t;

	logic clk;
	logic arst_n;

	tfc_in_if items();
	tfc_out_if results();
	tfc_cfg_if cfg();

	tank_fill_controller_with_timeout dut (
		.clk(clk),
		.arst_n(arst_n),
		.items(items),
		.results(results),
		.cfg(cfg)
	);

	// shadow of the controller
	logic [tfc_pkg::LEVEL_W-1:0] lvl_full, lvl_fill, lvl_warn, lvl_empty;
	logic [tfc_pkg::TICKS_W-1:0] fill_timeout;
	logic [1:0] mode_q;
	logic [tfc_pkg::TICKS_W-1:0] fill_ticks;
	logic valve_q;
	logic [2:0] lamp_q;

	tank_status_t pending_status [$];
	plan_row_t plan [$];

	int errors = 0;
	int items_sent = 0;
	int results_seen = 0;
	int reg_writes = 0;
	int lamp_changes = 0;
	int error_results = 0;
	int unsigned idle_cycles = 0;
	bit no_idle = 0;
	bit safe_mode = 1;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic void trip_error();
		mode_q = tfc_pkg::MODE_ERROR;
		valve_q = 1'b0;
		lamp_q = tfc_pkg::LAMP_RED;
	endfunction

	function automatic tank_status_t advance_tank(input logic is_tick,
			input logic [tfc_pkg::LEVEL_W-1:0] lvl);
		logic [2:0] prev;
		tank_status_t r;
		prev = lamp_q;
		if (is_tick) begin
			if (mode_q == tfc_pkg::MODE_FILLING) begin
				if (fill_ticks != '1)
					fill_ticks = fill_ticks + 1'b1;
				if (fill_ticks > fill_timeout)
					trip_error();
			end else begin
				fill_ticks = '0;
			end
		end else if (mode_q != tfc_pkg::MODE_ERROR) begin
			// checks run in order; later ones see the earlier changes
			if (lvl < lvl_full && mode_q != tfc_pkg::MODE_FULL) begin
				mode_q = tfc_pkg::MODE_FULL;
				valve_q = 1'b0;
				lamp_q = tfc_pkg::LAMP_BLUE;
			end
			if (lvl > lvl_fill && mode_q != tfc_pkg::MODE_FILLING) begin
				mode_q = tfc_pkg::MODE_FILLING;
				valve_q = 1'b1;
				lamp_q = tfc_pkg::LAMP_GREEN;
			end
			if (lvl > lvl_empty)
				trip_error();
			if (lvl > lvl_warn && mode_q == tfc_pkg::MODE_FILLING)
				lamp_q = tfc_pkg::LAMP_YELLOW;
		end
		r.valve_open = valve_q;
		r.tank_state = mode_q;
		r.lamp_colour = lamp_q;
		r.lamp_update = (lamp_q != prev);
		return r;
	endfunction

	function automatic void apply_reg(input logic [tfc_pkg::CFG_IDX_W-1:0] idx,
			input logic [tfc_pkg::CFG_DATA_W-1:0] data);
		case (idx)
			tfc_pkg::REG_FULL_LEVEL: lvl_full = data[tfc_pkg::LEVEL_W-1:0];
			tfc_pkg::REG_FILL_LEVEL: lvl_fill = data[tfc_pkg::LEVEL_W-1:0];
			tfc_pkg::REG_LOW_WARN_LEVEL: lvl_warn = data[tfc_pkg::LEVEL_W-1:0];
			tfc_pkg::REG_EMPTY_ERROR_LEVEL: lvl_empty = data[tfc_pkg::LEVEL_W-1:0];
			tfc_pkg::REG_FILL_TIMEOUT_TICKS: fill_timeout = data[tfc_pkg::TICKS_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic plan_row_t beat(input logic func,
			input logic [tfc_pkg::LEVEL_W-1:0] lvl);
		plan_row_t r;
		r = '0;
		r.func = func;
		r.level = lvl;
		return r;
	endfunction

	function automatic plan_row_t beat_chk(input logic func,
			input logic [tfc_pkg::LEVEL_W-1:0] lvl,
			input logic v, input logic [1:0] st, input logic [2:0] col, input logic upd);
		plan_row_t r;
		r = beat(func, lvl);
		r.typed = 1'b1;
		r.want.valve_open = v;
		r.want.tank_state = st;
		r.want.lamp_colour = col;
		r.want.lamp_update = upd;
		return r;
	endfunction

	function automatic plan_row_t reg_wr(input logic [tfc_pkg::CFG_IDX_W-1:0] idx,
			input logic [tfc_pkg::CFG_DATA_W-1:0] data);
		plan_row_t r;
		r = '0;
		r.is_reg = 1'b1;
		r.idx = idx;
		r.data = data;
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 50);
	endfunction

	// half near a threshold, a quarter extremes, a quarter uniform
	function automatic logic [tfc_pkg::LEVEL_W-1:0] pick_level();
		int t;
		case ($urandom_range(0, 3))
			0: return tfc_pkg::LEVEL_W'($urandom_range(0, 255));
			1: return ($urandom_range(0, 1) == 0) ? 8'd0 : 8'd255;
			default: begin
				case ($urandom_range(0, 3))
					0: t = int'(lvl_full);
					1: t = int'(lvl_fill);
					2: t = int'(lvl_warn);
					default: t = int'(lvl_empty);
				endcase
				t = t + $urandom_range(0, 2) - 1;
				if (t < 0)
					t = 0;
				if (t > 255)
					t = 255;
				return tfc_pkg::LEVEL_W'(t);
			end
		endcase
	endfunction

	task automatic drain_results();
		items.valid = 1'b0;
		do @(negedge clk); while (pending_status.size() != 0);
	endtask

	// called at a falling edge; valid stays high into back-to-back beats
	task automatic send_item(input logic func, input logic [tfc_pkg::LEVEL_W-1:0] lvl,
			input logic typed, input tank_status_t want);
		int gap;
		tank_status_t r;
		gap = pick_gap();
		if (gap > 0) begin
			items.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		items.valid = 1'b1;
		items.func = func;
		items.level_sample = lvl;
		do @(posedge clk); while (!items.ready);
		r = advance_tank(func, lvl);
		pending_status.push_back(typed ? want : r);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [tfc_pkg::CFG_IDX_W-1:0] idx,
			input logic [tfc_pkg::CFG_DATA_W-1:0] data);
		drain_results();
		cfg.valid = 1'b1;
		cfg.index = idx;
		cfg.data = data;
		do @(posedge clk); while (!cfg.ready);
		apply_reg(idx, data);
		reg_writes++;
		@(negedge clk);
		cfg.valid = 1'b0;
	endtask

	// level registers get random upper data bits, which must be dropped
	task automatic program_phase(input int ph);
		logic [tfc_pkg::LEVEL_W-1:0] lv [4];
		logic [tfc_pkg::TICKS_W-1:0] tmo;
		int base;
		int k;
		if (ph == 0) begin
			lv = '{8'd0, 8'd0, 8'd0, 8'd255};
			tmo = '0;
		end else if (ph == 1) begin
			lv = '{8'd255, 8'd255, 8'd255, 8'd255};
			tmo = 16'd65534;
		end else begin
			if ($urandom_range(0, 9) < 3 && ph != NUM_PHASES - 1) begin
				for (k = 0; k < 4; k++)
					lv[k] = tfc_pkg::LEVEL_W'($urandom_range(0, 255));
			end else begin
				base = $urandom_range(10, 200);
				for (k = 0; k < 4; k++) begin
					base = base + $urandom_range(0, 15);
					lv[k] = (base > 255) ? 8'd255 : tfc_pkg::LEVEL_W'(base);
				end
			end
			k = $urandom_range(0, 9);
			if (ph == NUM_PHASES - 1)
				tmo = tfc_pkg::TICKS_W'($urandom_range(0, 30));
			else if (k < 6)
				tmo = tfc_pkg::TICKS_W'($urandom_range(0, 40));
			else if (k < 8)
				tmo = tfc_pkg::TICKS_W'($urandom_range(0, 65534));
			else
				tmo = 16'd65534;
		end
		write_reg(tfc_pkg::REG_FULL_LEVEL, {8'($urandom), lv[0]});
		write_reg(tfc_pkg::REG_FILL_LEVEL, {8'($urandom), lv[1]});
		write_reg(tfc_pkg::REG_LOW_WARN_LEVEL, {8'($urandom), lv[2]});
		write_reg(tfc_pkg::REG_EMPTY_ERROR_LEVEL, {8'($urandom), lv[3]});
		write_reg(tfc_pkg::REG_FILL_TIMEOUT_TICKS, tmo);
		if ($urandom_range(0, 1) == 0)
			write_reg(tfc_pkg::CFG_IDX_W'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)),
				tfc_pkg::CFG_DATA_W'($urandom));
	endtask

	// result checker
	always @(posedge clk) begin
		tank_status_t got, want;
		if (results.valid && results.ready) begin
			got.valve_open = results.valve_open;
			got.tank_state = results.tank_state;
			got.lamp_colour = results.lamp_colour;
			got.lamp_update = results.lamp_update;
			results_seen++;
			if (got.lamp_update === 1'b1)
				lamp_changes++;
			if (got.tank_state === tfc_pkg::MODE_ERROR)
				error_results++;
			if (pending_status.size() == 0) begin
				errors++;
				$display("%0t: unexpected result beat valve %0d state %0d colour %0d update %0d",
					$time, got.valve_open, got.tank_state, got.lamp_colour, got.lamp_update);
			end else begin
				want = pending_status.pop_front();
				if (got !== want) begin
					errors++;
					$display("%0t: mismatch: expected valve %0d state %0d colour %0d update %0d",
						$time, want.valve_open, want.tank_state, want.lamp_colour,
						want.lamp_update);
					$display("%0t:           got valve %0d state %0d colour %0d update %0d",
						$time, got.valve_open, got.tank_state, got.lamp_colour,
						got.lamp_update);
				end
			end
		end
	end

	// watchdog: cycles with no beat on any channel
	always @(posedge clk) begin
		if ((items.valid && items.ready) || (results.valid && results.ready) ||
				(cfg.valid && cfg.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == IDLE_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
			$display("CHECK FAILED");
			$finish;
		end
	end

	// result sink with random backpressure
	initial begin
		int hold;
		int g;
		hold = 0;
		results.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (no_idle) begin
				results.ready = 1'b1;
				hold = 0;
			end else if (hold > 0) begin
				hold--;
			end else if (!results.ready) begin
				results.ready = 1'b1;
				hold = $urandom_range(1, 12);
			end else begin
				g = pick_gap();
				if (g > 0) begin
					results.ready = 1'b0;
					hold = g;
				end else begin
					hold = $urandom_range(1, 12);
				end
			end
		end
	end

	initial begin
		int ph;
		int i;
		int n;
		logic tk;
		logic [tfc_pkg::LEVEL_W-1:0] lv;
		plan_row_t row;

		arst_n = 1'b0;
		items.valid = 1'b0;
		items.func = FUNC_SAMPLE;
		items.level_sample = '0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;

		lvl_full = tfc_pkg::FULL_LEVEL_RST;
		lvl_fill = tfc_pkg::FILL_LEVEL_RST;
		lvl_warn = tfc_pkg::LOW_WARN_LEVEL_RST;
		lvl_empty = tfc_pkg::EMPTY_ERROR_LEVEL_RST;
		fill_timeout = tfc_pkg::FILL_TIMEOUT_RST;
		mode_q = tfc_pkg::MODE_INITIAL;
		fill_ticks = '0;
		valve_q = 1'b0;
		lamp_q = tfc_pkg::LAMP_OFF;

		// defaults after reset: full 145, fill 155, warn 165, empty 175
		plan.push_back(beat_chk(FUNC_TICK, 8'd0, 1'b0, tfc_pkg::MODE_INITIAL,
			tfc_pkg::LAMP_OFF, 1'b0));
		plan.push_back(beat_chk(FUNC_SAMPLE, 8'd150, 1'b0, tfc_pkg::MODE_INITIAL,
			tfc_pkg::LAMP_OFF, 1'b0));
		plan.push_back(beat_chk(FUNC_SAMPLE, 8'd0, 1'b0, tfc_pkg::MODE_FULL,
			tfc_pkg::LAMP_BLUE, 1'b1));
		plan.push_back(beat_chk(FUNC_SAMPLE, 8'd145, 1'b0, tfc_pkg::MODE_FULL,
			tfc_pkg::LAMP_BLUE, 1'b0));
		plan.push_back(beat_chk(FUNC_SAMPLE, 8'd155, 1'b0, tfc_pkg::MODE_FULL,
			tfc_pkg::LAMP_BLUE, 1'b0));
		plan.push_back(beat_chk(FUNC_SAMPLE, 8'd156, 1'b1, tfc_pkg::MODE_FILLING,
			tfc_pkg::LAMP_GREEN, 1'b1));
		plan.push_back(beat(FUNC_TICK, 8'd255));
		plan.push_back(beat(FUNC_SAMPLE, 8'd166));
		plan.push_back(beat(FUNC_SAMPLE, 8'd175));
		plan.push_back(beat(FUNC_SAMPLE, 8'd144));
		plan.push_back(beat(FUNC_TICK, 8'd0));
		// overlapping thresholds: full above fill, several checks fire per sample
		plan.push_back(reg_wr(tfc_pkg::REG_FULL_LEVEL, 16'hff00 | 16'd200));
		plan.push_back(reg_wr(tfc_pkg::REG_FILL_LEVEL, 16'd100));
		plan.push_back(reg_wr(tfc_pkg::REG_LOW_WARN_LEVEL, 16'd120));
		plan.push_back(reg_wr(tfc_pkg::REG_EMPTY_ERROR_LEVEL, 16'd255));
		plan.push_back(reg_wr(tfc_pkg::REG_FILL_TIMEOUT_TICKS, 16'd2));
		plan.push_back(reg_wr(REG_UNUSED_LO, 16'd0));
		plan.push_back(reg_wr(REG_UNUSED_HI, 16'hffff));
		plan.push_back(beat(FUNC_SAMPLE, 8'd150));
		plan.push_back(beat(FUNC_SAMPLE, 8'd110));
		plan.push_back(beat(FUNC_SAMPLE, 8'd150));
		// yellow -> blue -> green -> yellow inside one beat: no update strobe
		plan.push_back(beat(FUNC_SAMPLE, 8'd150));
		plan.push_back(beat(FUNC_TICK, 8'd0));
		plan.push_back(beat(FUNC_TICK, 8'd0));
		plan.push_back(beat(FUNC_SAMPLE, 8'd255));
		plan.push_back(reg_wr(tfc_pkg::REG_FULL_LEVEL, 16'd0));
		plan.push_back(reg_wr(tfc_pkg::REG_FILL_LEVEL, 16'd255));
		plan.push_back(beat(FUNC_SAMPLE, 8'd0));
		plan.push_back(beat(FUNC_SAMPLE, 8'd255));

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (plan[k]) begin
			row = plan[k];
			if (row.is_reg)
				write_reg(row.idx, row.data);
			else
				send_item(row.func, row.level, row.typed, row.want);
		end

		// last phase lets errors happen; error mode then holds to the end
		for (ph = 0; ph < NUM_PHASES; ph++) begin
			safe_mode = (ph != NUM_PHASES - 1);
			program_phase(ph);
			n = safe_mode ? 215 : 240;
			for (i = 0; i < n; i++) begin
				if (i % 48 == 0)
					no_idle = ($urandom_range(0, 3) == 0);
				if ($urandom_range(0, 149) == 0)
					drain_results();
				tk = ($urandom_range(0, 99) < 40);
				lv = pick_level();
				if (safe_mode) begin
					// keep clear of the latched error
					if (tk && mode_q == tfc_pkg::MODE_FILLING && fill_ticks >= fill_timeout) begin
						tk = FUNC_SAMPLE;
						lv = '0;
					end
					if (!tk && lv > lvl_empty)
						lv = lvl_empty;
				end
				send_item(tk, lv, 1'b0, '0);
			end
		end
		no_idle = 0;

		drain_results();
		repeat (8) @(negedge clk);

		$display("covered %0d items, %0d results, %0d register writes over %0d phases",
			items_sent, results_seen, reg_writes, NUM_PHASES);
		$display("lamp changes %0d, results in error mode %0d", lamp_changes, error_results);
		if (errors == 0 && pending_status.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d mismatches, %0d results outstanding", errors, pending_status.size());
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule
